// ----- src/indexed_list_store_macros.svh -----
// Assertion macros used by the checker of the indexed list store.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ils_pkg.sv -----
// Package with the types and constants of the indexed list store.
`default_nettype none

package ils_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ITEM_W    = 64;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 7;

	// Command codes.
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_GET    = 2'd1,
		OP_SET    = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET_WAIT,
		S_POP_TAKE,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t               cmd;
		logic [POS_W-1:0]  position;
		logic [ITEM_W-1:0] item_in;
	} cmd_item_t;

	typedef struct packed {
		logic [ITEM_W-1:0] item_out;
		logic [LEN_W-1:0]  length;
		status_t           status;
	} res_item_t;

	// Handshake between the sequencer and the result register.
	typedef struct packed {
		logic      load;
		res_item_t item;
	} res_load_t;

endpackage

`default_nettype wire

// ----- src/ils_mem.sv -----
// Item memory: one write port and one read port with registered read data.
`default_nettype none

module ils_mem import ils_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [ITEM_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [ITEM_W-1:0] rdata
);

	logic [ITEM_W-1:0] mem_q [DEPTH];
	logic [ITEM_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data valid in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/ils_ctrl.sv -----
// Command sequencer with the shared index incrementer and comparator.
`default_nettype none

module ils_ctrl import ils_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire cmd_item_t         cmd_item,
	input  wire logic              res_free,
	output res_load_t              res_load,
	output logic                   mem_we,
	output logic      [AW-1:0]     mem_waddr,
	output logic      [ITEM_W-1:0] mem_wdata,
	output logic      [AW-1:0]     mem_raddr,
	input  wire logic [ITEM_W-1:0] mem_rdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [AW-1:0]     wr_q, wr_d;
	op_t               op_q;
	logic [XW-1:0]     pos_q;
	logic [ITEM_W-1:0] val_q;
	logic [ITEM_W-1:0] rslt_q, rslt_d;
	status_t           stat_q, stat_d;

	logic [XW-1:0] inc_a, inc_y;
	logic [XW-1:0] cmp_a;
	logic          cmp_lt;
	logic          full;
	logic          accept;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign full      = (cnt_q == CW'(DEPTH));

	// Shared index unit: one incrementer and one compare against the count.
	assign inc_a  = (state_q == S_EXEC) ? pos_q : XW'(ptr_q);
	assign inc_y  = inc_a + XW'(1);
	assign cmp_a  = (state_q == S_EXEC) ? pos_q : XW'(ptr_q);
	assign cmp_lt = (cmp_a < XW'(cnt_q));

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Command and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd_item.cmd;
			pos_q <= XW'(cmd_item.position);
			val_q <= cmd_item.item_in;
		end
		ptr_q  <= ptr_d;
		wr_q   <= wr_d;
		rslt_q <= rslt_d;
		stat_q <= stat_d;
	end

	// Next state, memory control and result hand-off.
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		ptr_d         = ptr_q;
		wr_d          = wr_q;
		rslt_d        = rslt_q;
		stat_d        = stat_q;
		mem_we        = 1'b0;
		mem_waddr     = wr_q;
		mem_wdata     = mem_rdata;
		mem_raddr     = AW'(ptr_q);
		res_load.load = 1'b0;
		res_load.item = '{item_out: rslt_q, length: LEN_W'(cnt_q), status: stat_q};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rslt_d  = '0;
					stat_d  = ST_OK;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
				if (op_q == OP_APPEND) begin
					if (full) begin
						stat_d = ST_FULL;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = AW'(cnt_q);
						mem_wdata = val_q;
						cnt_d     = cnt_q + CW'(1);
					end
				end else if (!cmp_lt) begin
					stat_d = ST_RANGE;
				end else begin
					mem_raddr = AW'(pos_q);
					unique case (op_q)
						OP_GET: begin
							state_d = S_GET_WAIT;
						end
						OP_SET: begin
							mem_we    = 1'b1;
							mem_waddr = AW'(pos_q);
							mem_wdata = val_q;
						end
						OP_POP: begin
							ptr_d   = CW'(inc_y);
							wr_d    = AW'(pos_q);
							state_d = S_POP_TAKE;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_GET_WAIT: begin
				rslt_d  = mem_rdata;
				state_d = S_RESP;
			end
			S_POP_TAKE: begin
				rslt_d = mem_rdata;
				if (cmp_lt) begin
					ptr_d   = CW'(inc_y);
					state_d = S_SHIFT;
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				// Write back the entry read last cycle, one place lower.
				mem_we = 1'b1;
				wr_d   = wr_q + AW'(1);
				if (cmp_lt) begin
					ptr_d = CW'(inc_y);
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (res_free) begin
					res_load.load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/indexed_list_store.sv -----
// Indexed list store: bounded ordered list of 64-bit items with a length.
// Append, set and errors go from accept through execute to the result; get adds a
// wait for the registered read data, and pop runs a shift loop that moves one entry
// per cycle from the read port to the write port, each entry one place lower.
// A new item is accepted in the cycle after the result enters the output register.
// Reset clears the length and the control state; memory contents are not cleared.
`default_nettype none

module indexed_list_store import ils_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item
);

	localparam int AW = $clog2(DEPTH);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [ITEM_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [ITEM_W-1:0] mem_rdata;
	res_load_t         res_load;
	logic              res_free;
	logic              res_valid_q;
	res_item_t         res_item_q;

	ils_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_free  (res_free),
		.res_load  (res_load),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ils_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register is free when empty or being taken this cycle.
	assign res_free = !res_valid_q || !res_stall;

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load.load) begin
			res_item_q <= res_load.item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire

// ----- src/ils_checker.sv -----
// Port-level checker for the indexed list store and its bind.
`default_nettype none

`include "indexed_list_store_macros.svh"

module ils_checker import ils_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      cmd_valid,
	input wire logic      cmd_stall,
	input wire cmd_item_t cmd_item,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire res_item_t res_item
);

	// The block works on one item at a time after it accepts one.
	`ILS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "no stall after accept")

	// A stalled result stays valid and unchanged.
	`ILS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item), "result changed while stalled")

	// A full report only comes with the length at capacity.
	`ILS_ASSERT_NOW(a_full_len, res_valid && (res_item.status == ST_FULL), res_item.length == LEN_W'(DEPTH), "full with wrong length")

	// Errors return no item.
	`ILS_ASSERT_NOW(a_err_zero, res_valid && (res_item.status != ST_OK), res_item.item_out == '0, "error with nonzero item")

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);

`default_nettype wire
